[hdl/vrnt_pkg.sv]
// shared types, constants and lookup tables for the voice register note tracker
`timescale 1ns / 1ps
package vrnt_pkg;

    localparam int NUM_VOICES = 3;
    localparam int FRAME_BITS = 24;
    localparam int VOICE_W    = 2;
    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int SLOTS      = (2 * NUM_VOICES > 3) ? 2 * NUM_VOICES : 3;

    // event slots used by a voice item
    localparam int SLOT_TAIL  = 0;
    localparam int SLOT_HIT   = 1;
    localparam int SLOT_NOTE  = 2;

    localparam int FREQ_W  = 16;
    localparam int CLK_W   = 21;
    localparam int FPS_W   = 10;
    localparam int PROD_W  = FREQ_W + CLK_W;
    localparam int BOUND_W = PROD_W + 1;
    localparam int NBOUNDS = 128;
    localparam int MS_W    = 15;
    localparam int TAILP_W = MS_W + FPS_W;
    localparam int RECIP_W = 26;
    localparam int RECIP_SH = 35;
    localparam int LEN_W   = 15;

    localparam logic [PROD_W-1:0]  PITCH_FLOOR  = PROD_W'(64'd134217728);
    localparam logic [RECIP_W-1:0] RECIP_1000   = RECIP_W'(34359739);
    localparam logic [TAILP_W-1:0] ROUND_HALF   = TAILP_W'(500);
    localparam logic [FPS_W-1:0]   DEFAULT_FPS  = FPS_W'(50);
    localparam logic [3:0]         DRUM_MIN     = 4'd3;
    localparam logic [3:0]         DRUM_MAX     = 4'd12;
    localparam logic [6:0]         HIT_NOTE     = 7'd48;
    localparam logic [7:0]         HIT_WAVE     = 8'h80;
    localparam logic [1:0]         HIT_TRACK    = 2'd3;

    // control byte bit positions
    localparam int CTRL_GATE  = 0;
    localparam int CTRL_RING  = 2;
    localparam int CTRL_TEST  = 3;
    localparam int CTRL_NOISE = 7;

    typedef enum logic {
        OP_VOICE = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_CLOCK_HZ = 2'd0,
        CFG_FPS      = 2'd1,
        CFG_TOTAL    = 2'd2
    } cfg_idx_t;

    // raw input item
    typedef struct packed {
        op_t                 op;
        logic [VOICE_W-1:0]  voice;
        logic [FRAME_BITS-1:0] frame;
        logic [FREQ_W-1:0]   freq;
        logic [7:0]          ctrl;
        logic [7:0]          ad;
        logic [7:0]          sr;
    } raw_t;

    // item after the product stage
    typedef struct packed {
        op_t                 op;
        logic [VOICE_W-1:0]  voice;
        logic [FRAME_BITS-1:0] frame;
        logic [FREQ_W-1:0]   freq;
        logic [7:0]          ctrl;
        logic [6:0]          vel;
        logic [PROD_W-1:0]   prod;
        logic [TAILP_W-1:0]  drum_scaled;
        logic [TAILP_W-1:0]  rel_scaled;
    } mid_t;

    // item ready for the state update
    typedef struct packed {
        op_t                 op;
        logic [VOICE_W-1:0]  voice;
        logic [FRAME_BITS-1:0] frame;
        logic [FREQ_W-1:0]   freq;
        logic [7:0]          ctrl;
        logic [6:0]          vel;
        logic [6:0]          pitch;
        logic                no_pitch;
        logic [3:0]          drum_len;
        logic [LEN_W-1:0]    rel_len;
    } work_t;

    typedef struct packed {
        logic                  last;
        logic [6:0]            vel;
        logic [7:0]            wave;
        logic [FREQ_W-1:0]     freq;
        logic [6:0]            note;
        logic [FRAME_BITS-1:0] end_frame;
        logic [FRAME_BITS-1:0] start_frame;
        logic [1:0]            track;
    } ev_t;

    // release and decay lengths in milliseconds
    function automatic logic [MS_W-1:0] tail_ms(input logic [3:0] nib);
        logic [MS_W-1:0] r;
        case (nib)
            4'd0:    r = MS_W'(6);
            4'd1:    r = MS_W'(24);
            4'd2:    r = MS_W'(48);
            4'd3:    r = MS_W'(72);
            4'd4:    r = MS_W'(114);
            4'd5:    r = MS_W'(168);
            4'd6:    r = MS_W'(204);
            4'd7:    r = MS_W'(240);
            4'd8:    r = MS_W'(300);
            4'd9:    r = MS_W'(750);
            4'd10:   r = MS_W'(1500);
            4'd11:   r = MS_W'(2400);
            4'd12:   r = MS_W'(3000);
            4'd13:   r = MS_W'(9000);
            4'd14:   r = MS_W'(15000);
            default: r = MS_W'(24000);
        endcase
        return r;
    endfunction

    // velocity from the sustain nibble
    function automatic logic [6:0] vel_of(input logic [3:0] nib);
        logic [6:0] r;
        case (nib)
            4'd0:    r = 7'd80;
            4'd1:    r = 7'd83;
            4'd2:    r = 7'd86;
            4'd3:    r = 7'd89;
            4'd4:    r = 7'd92;
            4'd5:    r = 7'd95;
            4'd6:    r = 7'd98;
            4'd7:    r = 7'd101;
            4'd8:    r = 7'd105;
            4'd9:    r = 7'd108;
            4'd10:   r = 7'd111;
            4'd11:   r = 7'd114;
            4'd12:   r = 7'd117;
            4'd13:   r = 7'd120;
            4'd14:   r = 7'd123;
            default: r = 7'd127;
        endcase
        return r;
    endfunction

    // smallest product at or above the semitone boundary n, evaluated at elaboration
    function automatic logic [BOUND_W-1:0] pitch_bound(input int n);
        real    r;
        longint t;
        r = 55.0 * (2.0 ** ((509.0 + 2.0 * n) / 24.0));
        t = longint'(r);
        if (real'(t) < r) begin
            t = t + 64'sd1;
        end
        return t[BOUND_W-1:0];
    endfunction

endpackage

[hdl/vrnt_prep.sv]
// input register plus product and pitch stages feeding the note state update
`timescale 1ns / 1ps
module vrnt_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  vrnt_pkg::raw_t                in_item,
    input  logic [vrnt_pkg::CLK_W-1:0]    clock_hz,
    input  logic [vrnt_pkg::FPS_W-1:0]    fps,
    output logic                          work_valid,
    input  logic                          work_take,
    output vrnt_pkg::work_t               work_item
);
    import vrnt_pkg::*;

    logic                   v0_reg, v1_reg, v2_reg;
    raw_t                   st0_reg;
    mid_t                   st1_reg, st1_next;
    work_t                  st2_reg, st2_next;
    logic                   adv0, adv1, adv2;
    logic [FPS_W-1:0]       fps_eff;
    logic [BOUND_W-1:0]     bounds [NBOUNDS];
    logic [NBOUNDS-1:0]     ge;
    logic [7:0]             cnt;
    logic [TAILP_W+RECIP_W-1:0] drum_q, rel_q;
    logic [LEN_W-1:0]       drum_ms, rel_ms;
    logic [FPS_W:0]         rel_cap;

    // semitone boundary table
    always_comb begin
        for (int i = 0; i < NBOUNDS; i++) begin
            bounds[i] = pitch_bound(i + 1);
        end
    end

    assign fps_eff = (fps == '0) ? DEFAULT_FPS : fps;

    // stage advance, the last stage frees when the state update takes it
    assign adv2     = !v2_reg || work_take;
    assign adv1     = !v1_reg || adv2;
    assign adv0     = !v0_reg || adv1;
    assign in_ready = adv0;

    // product stage
    always_comb begin
        st1_next.op          = st0_reg.op;
        st1_next.voice       = st0_reg.voice;
        st1_next.frame       = st0_reg.frame;
        st1_next.freq        = st0_reg.freq;
        st1_next.ctrl        = st0_reg.ctrl;
        st1_next.vel         = vel_of(st0_reg.sr[7:4]);
        st1_next.prod        = PROD_W'(st0_reg.freq) * PROD_W'(clock_hz);
        st1_next.drum_scaled = TAILP_W'(tail_ms(st0_reg.ad[3:0])) * TAILP_W'(fps_eff)
                               + ROUND_HALF;
        st1_next.rel_scaled  = TAILP_W'(tail_ms(st0_reg.sr[3:0])) * TAILP_W'(fps_eff)
                               + ROUND_HALF;
    end

    // pitch compare and divide by 1000 through a reciprocal
    always_comb begin
        for (int i = 0; i < NBOUNDS; i++) begin
            ge[i] = {1'b0, st1_reg.prod} >= bounds[i];
        end
        cnt     = 8'($countones(ge));
        drum_q  = (TAILP_W+RECIP_W)'(st1_reg.drum_scaled) * (TAILP_W+RECIP_W)'(RECIP_1000);
        rel_q   = (TAILP_W+RECIP_W)'(st1_reg.rel_scaled) * (TAILP_W+RECIP_W)'(RECIP_1000);
        drum_ms = drum_q[RECIP_SH +: LEN_W];
        rel_ms  = rel_q[RECIP_SH +: LEN_W];
        rel_cap = {fps_eff, 1'b0};

        st2_next.op       = st1_reg.op;
        st2_next.voice    = st1_reg.voice;
        st2_next.frame    = st1_reg.frame;
        st2_next.freq     = st1_reg.freq;
        st2_next.ctrl     = st1_reg.ctrl;
        st2_next.vel      = st1_reg.vel;
        st2_next.pitch    = cnt[6:0];
        st2_next.no_pitch = (st1_reg.prod < PITCH_FLOOR) || cnt[7];
        if (drum_ms > LEN_W'(DRUM_MAX)) begin
            st2_next.drum_len = DRUM_MAX;
        end else if (drum_ms < LEN_W'(DRUM_MIN)) begin
            st2_next.drum_len = DRUM_MIN;
        end else begin
            st2_next.drum_len = drum_ms[3:0];
        end
        st2_next.rel_len = (rel_ms > LEN_W'(rel_cap)) ? LEN_W'(rel_cap) : rel_ms;
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv0) v0_reg <= in_valid;
            if (adv1) v1_reg <= v0_reg;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (adv0 && in_valid) st0_reg <= in_item;
        if (adv1 && v0_reg)   st1_reg <= st1_next;
        if (adv2 && v1_reg)   st2_reg <= st2_next;
    end

    assign work_valid = v2_reg;
    assign work_item  = st2_reg;

endmodule

[hdl/voice_register_note_tracker_top.sv]
// top level: configuration, per-voice note state, event buffer and output register
//
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata voice registers, s_tuser op
// m_        out  m_tvalid/m_tready    m_tdata note event, m_tlast last event of item
// cfg_      in   cfg_valid/cfg_ready  cfg_addr register index, cfg_data value
//
// an item passes the input, product and pitch stages, then updates the voice
// state; its events leave the output register one per cycle unless stalled.
// new items enter every cycle while each causes at most one event, unless stalled;
// an item with more events holds the state update until its last event moves out.
// reset is synchronous; there is no clearing pass, the block is ready right away.
`timescale 1ns / 1ps
module voice_register_note_tracker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // voice, frame_index, freq_word, control_byte,
                                   // attack_decay, sustain_release, zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // track, start_frame, end_frame, midi_note,
                                   // osc_freq, wave_bits, note_velocity
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_data
);
    import vrnt_pkg::*;

    logic [CLK_W-1:0]      clock_hz_reg;
    logic [FPS_W-1:0]      fps_reg;
    logic [FRAME_BITS-1:0] total_reg;

    raw_t  in_item;
    work_t wk;
    logic  wk_valid, commit;

    // per-voice state
    logic [NUM_VOICES-1:0] note_active_reg, note_active_next;
    logic [NUM_VOICES-1:0] note_rel_reg, note_rel_next;
    logic [NUM_VOICES-1:0] hit_active_reg, hit_active_next;
    logic [FRAME_BITS-1:0] note_start_reg [NUM_VOICES], note_start_next [NUM_VOICES];
    logic [FRAME_BITS-1:0] rel_end_reg [NUM_VOICES], rel_end_next [NUM_VOICES];
    logic [FRAME_BITS-1:0] hit_start_reg [NUM_VOICES], hit_start_next [NUM_VOICES];
    logic [6:0]            note_pitch_reg [NUM_VOICES], note_pitch_next [NUM_VOICES];
    logic [FREQ_W-1:0]     note_freq_reg [NUM_VOICES], note_freq_next [NUM_VOICES];
    logic [7:0]            note_wave_reg [NUM_VOICES], note_wave_next [NUM_VOICES];
    logic [6:0]            note_vel_reg [NUM_VOICES], note_vel_next [NUM_VOICES];
    logic [6:0]            hit_pitch_reg [NUM_VOICES], hit_pitch_next [NUM_VOICES];
    logic [6:0]            hit_vel_reg [NUM_VOICES], hit_vel_next [NUM_VOICES];
    logic [3:0]            hit_len_reg [NUM_VOICES], hit_len_next [NUM_VOICES];

    // event buffer and output register
    ev_t              ev_reg [SLOTS];
    ev_t              ev_new [SLOTS];
    logic [SLOTS-1:0] mask_reg, mask_new;
    ev_t              out_reg;
    logic             out_valid_reg;
    logic             move;
    logic [$clog2(SLOTS)-1:0] low_idx;

    // combinational work variables
    logic [VIDX_W-1:0]     vi;
    logic                  na, nr, ha, gate, ring;
    logic [FRAME_BITS-1:0] f, ne;
    logic [FRAME_BITS:0]   sum_e;
    logic [7:0]            wave;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLK_W'(985248);
            fps_reg      <= DEFAULT_FPS;
            total_reg    <= '1;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_CLOCK_HZ: clock_hz_reg <= cfg_data[CLK_W-1:0];
                CFG_FPS:      fps_reg      <= cfg_data[FPS_W-1:0];
                CFG_TOTAL:    total_reg    <= cfg_data[FRAME_BITS-1:0];
                default:      ;
            endcase
        end
    end

    assign in_item.op    = op_t'(s_tuser);
    assign in_item.voice = s_tdata[1:0];
    assign in_item.frame = s_tdata[25:2];
    assign in_item.freq  = s_tdata[41:26];
    assign in_item.ctrl  = s_tdata[49:42];
    assign in_item.ad    = s_tdata[57:50];
    assign in_item.sr    = s_tdata[65:58];

    vrnt_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .clock_hz   (clock_hz_reg),
        .fps        (fps_reg),
        .work_valid (wk_valid),
        .work_take  (commit),
        .work_item  (wk)
    );

    // lowest pending slot goes to the output register first
    always_comb begin
        low_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) low_idx = ($clog2(SLOTS))'(i);
        end
    end

    assign move   = (mask_reg != '0) && (!out_valid_reg || m_tready);
    assign commit = wk_valid && ((mask_reg == '0) || ($onehot(mask_reg) && move));

    // state update and event list for the item at the head of the pipeline
    always_comb begin
        note_active_next = note_active_reg;
        note_rel_next    = note_rel_reg;
        hit_active_next  = hit_active_reg;
        note_start_next  = note_start_reg;
        rel_end_next     = rel_end_reg;
        hit_start_next   = hit_start_reg;
        note_pitch_next  = note_pitch_reg;
        note_freq_next   = note_freq_reg;
        note_wave_next   = note_wave_reg;
        note_vel_next    = note_vel_reg;
        hit_pitch_next   = hit_pitch_reg;
        hit_vel_next     = hit_vel_reg;
        hit_len_next     = hit_len_reg;
        mask_new = '0;
        for (int i = 0; i < SLOTS; i++) ev_new[i] = '0;
        vi    = VIDX_W'(wk.voice);
        f     = wk.frame;
        wave  = wk.ctrl & 8'hF0;
        gate  = wk.ctrl[CTRL_GATE];
        ring  = wk.ctrl[CTRL_RING];
        na    = 1'b0;
        nr    = 1'b0;
        ha    = 1'b0;
        ne    = '0;
        sum_e = '0;

        if (wk.op == OP_FLUSH) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                if (note_active_reg[v]) begin
                    ne = (note_rel_reg[v] && rel_end_reg[v] < total_reg) ?
                         rel_end_reg[v] : total_reg;
                    if (ne > note_start_reg[v]) begin
                        mask_new[2*v] = 1'b1;
                        ev_new[2*v] = '{last: 1'b0, vel: note_vel_reg[v],
                            wave: note_wave_reg[v], freq: note_freq_reg[v],
                            note: note_pitch_reg[v], end_frame: ne,
                            start_frame: note_start_reg[v], track: 2'(v)};
                    end
                end
                if (hit_active_reg[v] && total_reg > hit_start_reg[v]) begin
                    mask_new[2*v+1] = 1'b1;
                    ev_new[2*v+1] = '{last: 1'b0, vel: hit_vel_reg[v], wave: HIT_WAVE,
                        freq: '0, note: hit_pitch_reg[v], end_frame: total_reg,
                        start_frame: hit_start_reg[v], track: HIT_TRACK};
                end
            end
            note_active_next = '0;
            note_rel_next    = '0;
            hit_active_next  = '0;
        end else if (32'(wk.voice) < NUM_VOICES) begin
            na = note_active_reg[vi];
            nr = note_rel_reg[vi];
            ha = hit_active_reg[vi];

            // release tail ran out
            if (na && nr && f >= rel_end_reg[vi]) begin
                if (rel_end_reg[vi] > note_start_reg[vi]) begin
                    mask_new[SLOT_TAIL] = 1'b1;
                    ev_new[SLOT_TAIL] = '{last: 1'b0, vel: note_vel_reg[vi],
                        wave: note_wave_reg[vi], freq: note_freq_reg[vi],
                        note: note_pitch_reg[vi], end_frame: rel_end_reg[vi],
                        start_frame: note_start_reg[vi], track: 2'(vi)};
                end
                na = 1'b0;
                nr = 1'b0;
            end

            if (!wk.ctrl[CTRL_TEST]) begin
                if (gate && wave[CTRL_NOISE]) begin
                    // noise gate opens a drum hit
                    if (!ha) begin
                        ha                 = 1'b1;
                        hit_start_next[vi] = f;
                        hit_pitch_next[vi] = wk.no_pitch ? HIT_NOTE : wk.pitch;
                        hit_vel_next[vi]   = wk.vel;
                        hit_len_next[vi]   = wk.drum_len;
                    end
                end else begin
                    // any other frame ends a running hit
                    if (ha) begin
                        sum_e = {1'b0, hit_start_reg[vi]} + (FRAME_BITS+1)'(hit_len_reg[vi]);
                        if ({1'b0, f} > sum_e) sum_e = {1'b0, f};
                        if (sum_e > {1'b0, total_reg}) sum_e = {1'b0, total_reg};
                        if (sum_e > {1'b0, hit_start_reg[vi]}) begin
                            mask_new[SLOT_HIT] = 1'b1;
                            ev_new[SLOT_HIT] = '{last: 1'b0, vel: hit_vel_reg[vi],
                                wave: HIT_WAVE, freq: '0, note: hit_pitch_reg[vi],
                                end_frame: sum_e[FRAME_BITS-1:0],
                                start_frame: hit_start_reg[vi], track: HIT_TRACK};
                        end
                    end
                    ha = 1'b0;

                    if (gate) begin
                        if (wk.no_pitch || (na && !ring &&
                                            (nr || wk.pitch != note_pitch_reg[vi]))) begin
                            // close the melodic note at this frame
                            if (na && f > note_start_reg[vi]) begin
                                mask_new[SLOT_NOTE] = 1'b1;
                                ev_new[SLOT_NOTE] = '{last: 1'b0, vel: note_vel_reg[vi],
                                    wave: note_wave_reg[vi], freq: note_freq_reg[vi],
                                    note: note_pitch_reg[vi], end_frame: f,
                                    start_frame: note_start_reg[vi], track: 2'(vi)};
                            end
                            na = 1'b0;
                            nr = 1'b0;
                        end
                        if (!wk.no_pitch) begin
                            if (!na) begin
                                if (!ring) begin
                                    na                  = 1'b1;
                                    nr                  = 1'b0;
                                    note_start_next[vi] = f;
                                    note_pitch_next[vi] = wk.pitch;
                                    note_freq_next[vi]  = wk.freq;
                                    note_wave_next[vi]  = wave;
                                    note_vel_next[vi]   = wk.vel;
                                    rel_end_next[vi]    = '0;
                                end
                            end else if (!nr && wk.pitch == note_pitch_reg[vi]) begin
                                note_wave_next[vi] = wave;
                                note_freq_next[vi] = wk.freq;
                            end
                        end
                    end else if (na && !nr) begin
                        // gate off starts the release tail, or ends the note if the tail is empty
                        if (wk.rel_len == '0) begin
                            if (f > note_start_reg[vi]) begin
                                mask_new[SLOT_NOTE] = 1'b1;
                                ev_new[SLOT_NOTE] = '{last: 1'b0, vel: note_vel_reg[vi],
                                    wave: note_wave_reg[vi], freq: note_freq_reg[vi],
                                    note: note_pitch_reg[vi], end_frame: f,
                                    start_frame: note_start_reg[vi], track: 2'(vi)};
                            end
                            na = 1'b0;
                        end else begin
                            nr    = 1'b1;
                            sum_e = {1'b0, f} + (FRAME_BITS+1)'(wk.rel_len);
                            rel_end_next[vi] = sum_e[FRAME_BITS] ? '1 : sum_e[FRAME_BITS-1:0];
                        end
                    end
                end
            end
            note_active_next[vi] = na;
            note_rel_next[vi]    = nr;
            hit_active_next[vi]  = ha;
        end

        // mark the final event of this item
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (mask_new[i] && ((mask_new >> (i + 1)) == '0)) ev_new[i].last = 1'b1;
        end
    end

    // voice state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_active_reg <= '0;
            note_rel_reg    <= '0;
            hit_active_reg  <= '0;
        end else if (commit) begin
            note_active_reg <= note_active_next;
            note_rel_reg    <= note_rel_next;
            hit_active_reg  <= hit_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            note_start_reg <= note_start_next;
            rel_end_reg    <= rel_end_next;
            hit_start_reg  <= hit_start_next;
            note_pitch_reg <= note_pitch_next;
            note_freq_reg  <= note_freq_next;
            note_wave_reg  <= note_wave_next;
            note_vel_reg   <= note_vel_next;
            hit_pitch_reg  <= hit_pitch_next;
            hit_vel_reg    <= hit_vel_next;
            hit_len_reg    <= hit_len_next;
        end
    end

    // event buffer pending mask and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (commit) begin
                mask_reg <= mask_new;
            end else if (move) begin
                mask_reg[low_idx] <= 1'b0;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) ev_reg <= ev_new;
        if (move)   out_reg <= ev_reg[low_idx];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.vel, out_reg.wave, out_reg.freq, out_reg.note,
                       out_reg.end_frame, out_reg.start_frame, out_reg.track};

    // a new item only lands on an empty buffer or one draining its final event
    a_commit_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (mask_reg == '0 || ($onehot(mask_reg) && move)))
        else $error("state update over pending events");

    // a flush leaves every voice closed
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && wk.op == OP_FLUSH) |=> (note_active_reg == '0 && hit_active_reg == '0))
        else $error("flush left a voice open");

    // a release tail belongs to an open note
    a_rel_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (note_rel_reg & ~note_active_reg) == '0)
        else $error("release tail without note");

    // an event only leaves the buffer into a free or draining output register
    a_move_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> $stable(out_reg))
        else $error("stalled event overwritten");

endmodule

[tb/voice_register_note_tracker_top_test.sv]
// self-checking testbench for the voice register note tracker
`timescale 1ns / 1ps
module voice_register_note_tracker_top_test;
    import vrnt_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 24;
    localparam logic [23:0] FRAME_MAX = 24'hFFFFFF;

    typedef struct {
        op_t         op;
        logic [1:0]  voice;
        logic [23:0] frame;
        logic [15:0] freq;
        logic [7:0]  ctrl;
        logic [7:0]  ad;
        logic [7:0]  sr;
    } regs_item_t;

    typedef struct packed {
        logic [1:0]  track;
        logic [23:0] start_frame;
        logic [23:0] end_frame;
        logic [6:0]  note;
        logic [15:0] freq;
        logic [7:0]  wave;
        logic [6:0]  vel;
        logic        last;
    } note_event_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // voice, frame_index, freq_word, control_byte,
                            // attack_decay, sustain_release, zero pad
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // track, start_frame, end_frame, midi_note,
                            // osc_freq, wave_bits, note_velocity
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_addr;
    logic [23:0] cfg_data;

    voice_register_note_tracker_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // tracker configuration and per-voice state as predicted
    logic [20:0] osc_clock;
    logic [9:0]  capture_fps;
    logic [23:0] capture_frames;
    logic        mel_on [3]      = '{default: 1'b0};
    logic        mel_rel [3]     = '{default: 1'b0};
    logic [23:0] mel_start [3]   = '{default: 24'd0};
    logic [23:0] mel_rel_end [3] = '{default: 24'd0};
    logic [6:0]  mel_note [3]    = '{default: 7'd0};
    logic [15:0] mel_freq [3]    = '{default: 16'd0};
    logic [7:0]  mel_wave [3]    = '{default: 8'd0};
    logic [6:0]  mel_vel [3]     = '{default: 7'd100};
    logic        drum_on [3]     = '{default: 1'b0};
    logic [23:0] drum_start [3]  = '{default: 24'd0};
    logic [6:0]  drum_note [3]   = '{default: 7'd48};
    logic [6:0]  drum_vel [3]    = '{default: 7'd100};
    logic [3:0]  drum_len [3]    = '{default: 4'd1};

    regs_item_t  pending_items[$];
    note_event_t note_events_due[$];
    note_event_t step_events[$];
    regs_item_t  cur_item;
    logic        s_took = 1'b0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches = 0;
    int          events_seen = 0;
    int          items_taken = 0;
    int          idle_cycles = 0;

    // midi note from frequency register: count of semitone boundaries passed
    function automatic int midi_of(input logic [15:0] f);
        logic [63:0]   p;
        logic [1023:0] x;
        logic [1023:0] y;
        int            n;
        p = 64'(f) * 64'(osc_clock);
        if (p < 64'd134217728) return -1;
        x = 1;
        y = 1;
        for (int i = 0; i < 24; i++) begin
            x = x * p;
            y = y * 1024'd55;
        end
        y = y << 511;
        n = 0;
        while (n < 128 && x >= y) begin
            n++;
            y = y << 2;
        end
        return (n >= 128) ? -1 : n;
    endfunction

    function automatic logic [63:0] fps_eff();
        return (capture_fps == 0) ? 64'd50 : 64'(capture_fps);
    endfunction

    // release or decay length in frames, rounded half up and capped
    function automatic logic [63:0] tail_frames(input logic [3:0] nib, input logic [63:0] cap);
        int unsigned ms [16] = '{6, 24, 48, 72, 114, 168, 204, 240,
                                 300, 750, 1500, 2400, 3000, 9000, 15000, 24000};
        logic [63:0] r;
        r = (64'(ms[nib]) * fps_eff() + 64'd500) / 64'd1000;
        return (r > cap) ? cap : r;
    endfunction

    function automatic logic [6:0] velocity_of(input logic [7:0] sr);
        return 7'(80 + (int'(sr[7:4]) * 47) / 15);
    endfunction

    function automatic void add_event(input logic [1:0] trk, input logic [23:0] st,
                                      input logic [23:0] en, input logic [6:0] nt,
                                      input logic [15:0] fq, input logic [7:0] wv,
                                      input logic [6:0] vl);
        note_event_t e;
        e.track = trk;
        e.start_frame = st;
        e.end_frame = en;
        e.note = nt;
        e.freq = fq;
        e.wave = wv;
        e.vel = vl;
        e.last = 1'b0;
        step_events.insert(step_events.size(), e);
    endfunction

    function automatic void end_melody(input int v, input logic [23:0] en);
        if (mel_on[v] && en > mel_start[v])
            add_event(2'(v), mel_start[v], en, mel_note[v], mel_freq[v], mel_wave[v],
                      mel_vel[v]);
        mel_on[v] = 1'b0;
        mel_rel[v] = 1'b0;
    endfunction

    function automatic void end_drum(input int v, input logic [23:0] en);
        logic [63:0] e;
        if (drum_on[v]) begin
            e = 64'(drum_start[v]) + 64'(drum_len[v]);
            if (64'(en) > e) e = 64'(en);
            if (e > 64'(capture_frames)) e = 64'(capture_frames);
            if (e > 64'(drum_start[v]))
                add_event(HIT_TRACK, drum_start[v], 24'(e), drum_note[v], 16'd0, 8'h80,
                          drum_vel[v]);
        end
        drum_on[v] = 1'b0;
    endfunction

    function automatic void begin_melody(input int v, input regs_item_t it, input int pn);
        mel_on[v] = 1'b1;
        mel_rel[v] = 1'b0;
        mel_start[v] = it.frame;
        mel_note[v] = 7'(pn);
        mel_freq[v] = it.freq;
        mel_wave[v] = it.ctrl & 8'hF0;
        mel_vel[v] = velocity_of(it.sr);
        mel_rel_end[v] = '0;
    endfunction

    // work out the note events one accepted item causes
    function automatic void predict_note_events(input regs_item_t it);
        int          v;
        int          pn;
        logic        gate;
        logic        ring;
        logic [63:0] len;
        logic [63:0] e;
        step_events.delete();
        v = int'(it.voice);
        gate = it.ctrl[CTRL_GATE];
        ring = it.ctrl[CTRL_RING];
        if (it.op == OP_FLUSH) begin
            for (int k = 0; k < 3; k++) begin
                if (mel_on[k])
                    end_melody(k, (mel_rel[k] && mel_rel_end[k] < capture_frames) ?
                                  mel_rel_end[k] : capture_frames);
                if (drum_on[k]) end_drum(k, capture_frames);
            end
        end else if (v < 3) begin
            // an expired release tail is closed before anything else
            if (mel_on[v] && mel_rel[v] && it.frame >= mel_rel_end[v])
                end_melody(v, mel_rel_end[v]);
            if (!it.ctrl[CTRL_TEST]) begin
                if (gate && it.ctrl[CTRL_NOISE]) begin
                    // gated noise starts a drum hit unless one is already open
                    if (!drum_on[v]) begin
                        pn = midi_of(it.freq);
                        len = tail_frames(it.ad[3:0], 64'd12);
                        drum_on[v] = 1'b1;
                        drum_start[v] = it.frame;
                        drum_note[v] = (pn < 0) ? 7'd48 : 7'(pn);
                        drum_vel[v] = velocity_of(it.sr);
                        drum_len[v] = (len < 3) ? 4'd3 : 4'(len);
                    end
                end else begin
                    end_drum(v, it.frame);
                    if (gate) begin
                        pn = midi_of(it.freq);
                        if (pn < 0) begin
                            end_melody(v, it.frame);
                        end else if (!mel_on[v]) begin
                            if (!ring) begin_melody(v, it, pn);
                        end else if (mel_rel[v] || 7'(pn) != mel_note[v]) begin
                            if (!ring) begin
                                end_melody(v, it.frame);
                                begin_melody(v, it, pn);
                            end
                        end else begin
                            mel_wave[v] = it.ctrl & 8'hF0;
                            mel_freq[v] = it.freq;
                        end
                    end else if (mel_on[v] && !mel_rel[v]) begin
                        // gate off starts the release tail, or ends the note if the tail is empty
                        len = tail_frames(it.sr[3:0], fps_eff() * 2);
                        if (len == 0) begin
                            end_melody(v, it.frame);
                        end else begin
                            e = 64'(it.frame) + len;
                            mel_rel[v] = 1'b1;
                            mel_rel_end[v] = (e > 64'(FRAME_MAX)) ? FRAME_MAX : 24'(e);
                        end
                    end
                end
            end
        end
        if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i]) note_events_due.insert(note_events_due.size(), step_events[i]);
    endfunction

    // input driver: holds an item until its transfer, idles at random in between; also drives m_tready
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || s_took) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_item.op;
                    s_tdata <= {6'b0, cur_item.sr, cur_item.ad, cur_item.ctrl,
                                cur_item.freq, cur_item.frame, cur_item.voice};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge aclk) begin
        note_event_t got;
        note_event_t want;
        s_took = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_took) begin
                items_taken++;
                predict_note_events(cur_item);
            end
            if (m_tvalid && m_tready) begin
                events_seen++;
                got.track = m_tdata[1:0];
                got.start_frame = m_tdata[25:2];
                got.end_frame = m_tdata[49:26];
                got.note = m_tdata[56:50];
                got.freq = m_tdata[72:57];
                got.wave = m_tdata[80:73];
                got.vel = m_tdata[87:81];
                got.last = m_tlast;
                if (note_events_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event: trk=%0d start=%0d end=%0d note=%0d",
                                 got.track, got.start_frame, got.end_frame, got.note);
                end else begin
                    want = note_events_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("event mismatch at %0t", $realtime);
                            $display("  exp trk=%0d st=%0d end=%0d note=%0d",
                                     want.track, want.start_frame, want.end_frame,
                                     want.note);
                            $display("      fq=%h wv=%h vel=%0d last=%0d",
                                     want.freq, want.wave, want.vel, want.last);
                            $display("  got trk=%0d st=%0d end=%0d note=%0d",
                                     got.track, got.start_frame, got.end_frame,
                                     got.note);
                            $display("      fq=%h wv=%h vel=%0d last=%0d",
                                     got.freq, got.wave, got.vel, got.last);
                        end
                    end
                end
            end
            // watchdog on cycles without any transfer
            if (s_took || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d events outstanding",
                         note_events_due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CLOCK_HZ: osc_clock = value[20:0];
            CFG_FPS:      capture_fps = value[9:0];
            default:      capture_frames = value;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_item(input op_t op, input logic [1:0] voice, input logic [23:0] frame,
                              input logic [15:0] freq, input logic [7:0] ctrl,
                              input logic [7:0] ad, input logic [7:0] sr);
        regs_item_t it;
        it.op = op;
        it.voice = voice;
        it.frame = frame;
        it.freq = freq;
        it.ctrl = ctrl;
        it.ad = ad;
        it.sr = sr;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_items.size() > 0 || s_tvalid || note_events_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random frames, voices in order within a frame that mostly rises, mostly musical register patterns
    task automatic queue_random_song(input int count);
        logic [23:0] f;
        logic [15:0] held_freq [3];
        logic [7:0]  ctrl;
        int          r;
        int          n;
        f = 24'($urandom_range(0, 2000));
        for (int k = 0; k < 3; k++) held_freq[k] = 16'($urandom);
        n = 0;
        while (n < count) begin
            for (int v = 0; v < 3; v++) begin
                if ($urandom_range(99) < 30) begin
                    held_freq[v] = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 300))
                                                            : 16'($urandom);
                end
                r = $urandom_range(99);
                if (r < 40)
                    ctrl = {1'b0, 3'($urandom), 4'b0001} |
                           (($urandom_range(9) == 0) ? 8'h04 : 8'h00) |
                           (($urandom_range(9) == 0) ? 8'h02 : 8'h00);
                else if (r < 58)
                    ctrl = {1'b1, 3'($urandom), 4'b0001} |
                           (($urandom_range(5) == 0) ? 8'h04 : 8'h00);
                else if (r < 83)
                    ctrl = {4'($urandom), 1'b0, 1'($urandom), 1'($urandom), 1'b0};
                else if (r < 88)
                    ctrl = 8'($urandom) | 8'h08;
                else
                    ctrl = 8'($urandom);
                queue_item(OP_VOICE, 2'(v), f, held_freq[v], ctrl, 8'($urandom),
                           8'($urandom));
                n++;
            end
            // an odd item for the missing voice, ignored by the block
            if ($urandom_range(19) == 0)
                queue_item(OP_VOICE, 2'd3, f, 16'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
            if ($urandom_range(29) == 0 && f > 20)
                f = f - 24'($urandom_range(1, 20));
            else
                f = f + 24'($urandom_range(0, 4));
        end
        queue_item(OP_FLUSH, 2'($urandom), 24'($urandom), 16'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic [23:0] clk_hz,
                             input logic [23:0] fps, input logic [23:0] frames,
                             input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(CFG_CLOCK_HZ, clk_hz);
        write_reg(CFG_FPS, fps);
        write_reg(CFG_TOTAL, frames);
        queue_random_song(count);
        drain();
    endtask

    // stimulus sequence
    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr = CFG_CLOCK_HZ;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        osc_clock = 21'd985248;
        capture_fps = 10'd50;
        capture_frames = FRAME_MAX;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings
        queue_item(OP_VOICE, 2'd0, 24'd0, 16'h1CD6, 8'h11, 8'h00, 8'h00);
        queue_item(OP_VOICE, 2'd0, 24'd1, 16'h1CD6, 8'h21, 8'h00, 8'h00);
        queue_item(OP_VOICE, 2'd0, 24'd2, 16'h2400, 8'h41, 8'h00, 8'h00);
        // release nibble of zero rounds to no tail
        queue_item(OP_VOICE, 2'd0, 24'd3, 16'h2400, 8'h40, 8'h00, 8'h00);
        queue_item(OP_VOICE, 2'd1, 24'd3, 16'hFFFF, 8'h41, 8'h00, 8'hFF);
        queue_item(OP_VOICE, 2'd1, 24'd5, 16'hFFFF, 8'h40, 8'h00, 8'h0F);
        // expired tail closes even on a test-bit frame
        queue_item(OP_VOICE, 2'd1, 24'd200, 16'h0000, 8'h08, 8'h00, 8'h00);
        queue_item(OP_VOICE, 2'd2, 24'd10, 16'h0000, 8'h81, 8'h0F, 8'h70);
        queue_item(OP_VOICE, 2'd2, 24'd11, 16'h1000, 8'h81, 8'h00, 8'h00);
        queue_item(OP_VOICE, 2'd2, 24'd30, 16'h1000, 8'h00, 8'h00, 8'h00);
        // ring-mod gate never opens a note
        queue_item(OP_VOICE, 2'd0, 24'd31, 16'h1000, 8'h15, 8'h00, 8'h00);
        queue_item(OP_VOICE, 2'd0, 24'd33, 16'h2000, 8'h11, 8'h00, 8'h30);
        // unpitched gate closes the open note
        queue_item(OP_VOICE, 2'd0, 24'd34, 16'h000A, 8'h11, 8'h00, 8'h30);
        queue_item(OP_VOICE, 2'd3, 24'd35, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        // release end saturates near the top of the frame range
        queue_item(OP_VOICE, 2'd2, 24'hFFFFF0, 16'h8000, 8'h41, 8'h00, 8'hFE);
        queue_item(OP_VOICE, 2'd2, 24'hFFFFF8, 16'h8000, 8'h40, 8'h00, 8'hFE);
        queue_item(OP_VOICE, 2'd0, 24'hFFFFF9, 16'h0050, 8'h81, 8'h00, 8'h00);
        queue_item(OP_VOICE, 2'd1, 24'hFFFFFA, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        queue_item(OP_FLUSH, 2'd3, 24'hABCDEF, 16'h5A5A, 8'hA5, 8'h5A, 8'hA5);
        // frames going backwards drop the note that would end before it began
        queue_item(OP_VOICE, 2'd0, 24'd100, 16'h1CD6, 8'h11, 8'h00, 8'h50);
        queue_item(OP_VOICE, 2'd0, 24'd101, 16'h1CD6, 8'h10, 8'h00, 8'h5C);
        queue_item(OP_VOICE, 2'd0, 24'd40, 16'h1CD6, 8'h11, 8'h00, 8'h50);
        queue_item(OP_VOICE, 2'd1, 24'd41, 16'h0001, 8'h81, 8'h09, 8'h20);
        queue_item(OP_FLUSH, 2'd0, 24'd0, 16'h0000, 8'h00, 8'h00, 8'h00);
        drain();

        // random phases across settings and flow-control patterns
        run_phase(0, 0, 24'd985248, 24'd50, 24'hFFFFFF, 48);
        run_phase(75, 0, 24'd2000000, 24'd1000, 24'hFFFFFF, 48);
        run_phase(0, 75, 24'd1, 24'd1, 24'd300, 45);
        run_phase(7, 7, 24'd0, 24'd0, 24'd0, 45);
        run_phase(0, 0, 24'd1022727, 24'd60, 24'd700, 48);

        $display("run covered %0d items and %0d note events over 6 settings",
                 items_taken, events_seen);
        $display("flow control: free running, sparse sender, stalled receiver, light jitter");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatched events", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/vrnt_pkg.sv
hdl/vrnt_prep.sv
hdl/voice_register_note_tracker_top.sv
tb/voice_register_note_tracker_top_test.sv
